@@ src/tdpc_pkg.sv @@
// Package with shared types and constants of the trial-division prime counter.
`timescale 1ns / 1ps

package tdpc_pkg;

  // Default widths of the element value and of the position and prime counters.
  localparam int unsigned ValueWidthDef = 32;
  localparam int unsigned CountWidthDef = 16;

  // Width of the position and prime count result fields.
  localparam int unsigned OutWidth = 16;

  // The divisor register rests at two between elements.
  localparam int unsigned RestDivisor = 2;
  // First divisor tried for an odd value, and its square.
  localparam int unsigned FirstOddDivisor = 3;
  localparam int unsigned FirstOddSquare = 9;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLASSIFY,
    S_CHECK,
    S_DIVIDE,
    S_TEST,
    S_DONE_PRIME,
    S_DONE_COMP
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // take the input transfer into the datapath
    logic div_start;  // begin a serial remainder by the current divisor
    logic div_step;   // one restoring remainder step
    logic next_div;   // advance to the next odd divisor
    logic finish;     // write the result register and update the count
    logic prime;      // verdict that goes with finish
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic trivial;        // zero, one, two or an even value
    logic trivial_prime;  // the value is two
    logic sq_gt;          // square of the divisor exceeds the value
    logic div_last;       // last bit of the serial remainder
    logic rem_zero;       // remainder is zero
    logic out_free;       // the result register can take a new result
  } stat_t;

endpackage

@@ src/trial_division_prime_counter.sv @@
// Top level of the trial-division prime counter.
`timescale 1ns / 1ps

// Tests each element of a stream for primality and reports, for every element, a prime
// flag, its zero-based position in its array and the running number of primes in that
// array, this element included. A transfer with start_of_array_i high opens a new array:
// count and position are cleared before that element. Both counters saturate at their
// maximum. One element is worked on at a time. Zero, one, two and even values are
// settled by the classify step and go straight to the result write. Odd values run a
// divisor search: each odd trial divisor from 3 upward takes a compare of the divisor
// square against the value, a bit-serial restoring remainder of VALUE_WIDTH steps, and
// a zero test. The search ends with a prime verdict once the divisor square exceeds the
// value, or sooner with a composite verdict when a divisor leaves a zero remainder.
// After a result is written the block returns to idle before it takes the next element,
// and a result that still waits on the output holds back the write of the following one.
// The result sits in an output register, so the next element transfer is taken while
// a finished result still waits on the output.
module trial_division_prime_counter #(
  parameter int unsigned VALUE_WIDTH = tdpc_pkg::ValueWidthDef,
  parameter int unsigned COUNT_WIDTH = tdpc_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [VALUE_WIDTH-1:0]        value_i,
  input  logic                          start_of_array_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          is_prime_o,
  output logic [tdpc_pkg::OutWidth-1:0] position_o,
  output logic [tdpc_pkg::OutWidth-1:0] prime_count_o
);

  tdpc_pkg::cmd_t  cmd;
  tdpc_pkg::stat_t stat;

  // The controller sequences the classification, the divisor loop and the result write.
  tdpc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the element, the divisor and its square, the remainder unit,
  // the array counters and the result register.
  tdpc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .value_i          (value_i),
    .start_of_array_i (start_of_array_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .out_ready_i      (out_ready_i),
    .out_valid_o      (out_valid_o),
    .is_prime_o       (is_prime_o),
    .position_o       (position_o),
    .prime_count_o    (prime_count_o)
  );

endmodule

@@ src/tdpc_ctrl.sv @@
// Controller state machine of the trial-division prime counter.
`timescale 1ns / 1ps

module tdpc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tdpc_pkg::stat_t stat_i,
  output tdpc_pkg::cmd_t  cmd_o
);

  tdpc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tdpc_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      tdpc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = tdpc_pkg::S_CLASSIFY;
        end
      end
      tdpc_pkg::S_CLASSIFY: begin
        if (stat_i.trivial) begin
          state_d = stat_i.trivial_prime ? tdpc_pkg::S_DONE_PRIME : tdpc_pkg::S_DONE_COMP;
        end else begin
          state_d = tdpc_pkg::S_CHECK;
        end
      end
      tdpc_pkg::S_CHECK: begin
        if (stat_i.sq_gt) begin
          state_d = tdpc_pkg::S_DONE_PRIME;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = tdpc_pkg::S_DIVIDE;
        end
      end
      tdpc_pkg::S_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (stat_i.div_last) begin
          state_d = tdpc_pkg::S_TEST;
        end
      end
      tdpc_pkg::S_TEST: begin
        if (stat_i.rem_zero) begin
          state_d = tdpc_pkg::S_DONE_COMP;
        end else begin
          cmd_o.next_div = 1'b1;
          state_d        = tdpc_pkg::S_CHECK;
        end
      end
      tdpc_pkg::S_DONE_PRIME: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          cmd_o.prime  = 1'b1;
          state_d      = tdpc_pkg::S_IDLE;
        end
      end
      tdpc_pkg::S_DONE_COMP: begin
        if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = tdpc_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tdpc_pkg::S_IDLE;
      end
    endcase
  end

  // A result is only written when the result register can hold it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> stat_i.out_free)
    else $error("result written while the result register is occupied");

  // A new element is never taken while a remainder is being worked out.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_step |=> !cmd_o.load)
    else $error("input taken directly after a remainder step");

  // An element is loaded only on an input transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (in_valid_i && in_ready_o))
    else $error("element loaded without an input transfer");

endmodule

@@ src/tdpc_datapath.sv @@
// Datapath of the trial-division prime counter: divisor search, serial remainder, counters.
`timescale 1ns / 1ps

module tdpc_datapath #(
  parameter int unsigned VALUE_WIDTH = tdpc_pkg::ValueWidthDef,
  parameter int unsigned COUNT_WIDTH = tdpc_pkg::CountWidthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [VALUE_WIDTH-1:0]        value_i,
  input  logic                          start_of_array_i,
  input  tdpc_pkg::cmd_t                cmd_i,
  output tdpc_pkg::stat_t               stat_o,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic                          is_prime_o,
  output logic [tdpc_pkg::OutWidth-1:0] position_o,
  output logic [tdpc_pkg::OutWidth-1:0] prime_count_o
);

  localparam int unsigned DivWidth    = (VALUE_WIDTH + 1) / 2 + 1;
  localparam int unsigned SqWidth     = 2 * DivWidth;
  localparam int unsigned BitCntWidth = $clog2(VALUE_WIDTH);
  localparam logic [COUNT_WIDTH-1:0] CountMax = {COUNT_WIDTH{1'b1}};

  logic [VALUE_WIDTH-1:0] val_q;
  logic [DivWidth-1:0]    div_q;
  logic [SqWidth-1:0]     sq_q;
  logic [DivWidth-1:0]    rem_q, rem_d;
  logic [VALUE_WIDTH-1:0] shift_q;
  logic [BitCntWidth-1:0] bit_q;
  logic [COUNT_WIDTH-1:0] idx_q, count_q;
  logic [COUNT_WIDTH-1:0] pos_q;
  logic [COUNT_WIDTH-1:0] idx_base, count_base, count_new;
  logic                   out_valid_q;
  logic                   is_prime_q;
  logic [tdpc_pkg::OutWidth-1:0] position_q, prime_count_q;

  logic [DivWidth:0] rem_ext, rem_diff;
  logic [31:0]       idx_ext, count_ext;

  // One restoring remainder step: bring in the next bit, subtract when it fits.
  assign rem_ext  = {rem_q, shift_q[VALUE_WIDTH-1]};
  assign rem_diff = rem_ext - {1'b0, div_q};
  assign rem_d    = (rem_ext >= {1'b0, div_q}) ? rem_diff[DivWidth-1:0]
                                               : rem_ext[DivWidth-1:0];

  assign idx_base   = start_of_array_i ? '0 : idx_q;
  assign count_base = start_of_array_i ? '0 : count_q;
  assign count_new  = (cmd_i.prime && (count_q != CountMax)) ?
                      count_q + COUNT_WIDTH'(1) : count_q;
  assign idx_ext    = 32'(pos_q);
  assign count_ext  = 32'(count_new);

  assign stat_o.trivial       = (val_q < VALUE_WIDTH'(2)) || !val_q[0];
  assign stat_o.trivial_prime = (val_q == VALUE_WIDTH'(2));
  assign stat_o.sq_gt         = (sq_q > SqWidth'(val_q));
  assign stat_o.div_last      = (bit_q == '0);
  assign stat_o.rem_zero      = (rem_q == '0);
  assign stat_o.out_free      = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      val_q       <= '0;
      div_q       <= DivWidth'(tdpc_pkg::RestDivisor);
      idx_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        val_q   <= value_i;
        div_q   <= DivWidth'(tdpc_pkg::FirstOddDivisor);
        idx_q   <= (idx_base == CountMax) ? idx_base : idx_base + COUNT_WIDTH'(1);
        count_q <= count_base;
      end
      if (cmd_i.next_div) begin
        div_q <= div_q + DivWidth'(2);
      end
      if (cmd_i.finish) begin
        div_q       <= DivWidth'(tdpc_pkg::RestDivisor);
        count_q     <= count_new;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sq_q  <= SqWidth'(tdpc_pkg::FirstOddSquare);
      pos_q <= idx_base;
    end
    if (cmd_i.next_div) begin
      // (d + 2)^2 = d^2 + 4d + 4
      sq_q <= sq_q + (SqWidth'(div_q) << 2) + SqWidth'(4);
    end
    if (cmd_i.div_start) begin
      rem_q   <= '0;
      shift_q <= val_q;
      bit_q   <= BitCntWidth'(VALUE_WIDTH - 1);
    end
    if (cmd_i.div_step) begin
      rem_q   <= rem_d;
      shift_q <= shift_q << 1;
      bit_q   <= bit_q - BitCntWidth'(1);
    end
    if (cmd_i.finish) begin
      is_prime_q    <= cmd_i.prime;
      position_q    <= idx_ext[tdpc_pkg::OutWidth-1:0];
      prime_count_q <= count_ext[tdpc_pkg::OutWidth-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign is_prime_o    = is_prime_q;
  assign position_o    = position_q;
  assign prime_count_o = prime_count_q;

  // The partial remainder stays below the divisor throughout the serial step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < div_q))
    else $error("partial remainder not below divisor");

  // Only odd divisors are tried.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> div_q[0])
    else $error("even trial divisor");

  // The prime count can never pass the element index.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= idx_q)
    else $error("prime count exceeds element index");

endmodule
